@@ hdl/assert_macros.svh @@
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge of the clock, off while reset is high.
`define ASSERT_ALWAYS(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// Implication checked at every rising edge of the clock, off while reset is high.
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

@@ hdl/sacl_pkg.sv @@
// Package with the constants and codes of the set-associative cache simulator.
`timescale 1ns / 1ps
package sacl_pkg;

  localparam int MAX_SET_BITS_DEF = 8;
  localparam int MAX_WAYS_DEF     = 8;
  localparam int ADDR_BITS_DEF    = 48;

  localparam int AGE_W   = 32;
  localparam int CNT_W   = 32;
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  localparam logic [1:0] REQ_LOAD   = 2'd0;
  localparam logic [1:0] REQ_STORE  = 2'd1;
  localparam logic [1:0] REQ_MODIFY = 2'd2;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  localparam logic [1:0] OUT_HIT   = 2'd0;
  localparam logic [1:0] OUT_MISS  = 2'd1;
  localparam logic [1:0] OUT_EVICT = 2'd2;

  localparam logic [1:0] REG_SET_BITS    = 2'd0;
  localparam logic [1:0] REG_WAYS_IN_USE = 2'd1;
  localparam logic [1:0] REG_BLOCK_BITS  = 2'd2;

  localparam logic [3:0] SET_BITS_RST    = 4'd4;
  localparam logic [3:0] WAYS_IN_USE_RST = 4'd1;
  localparam logic [4:0] BLOCK_BITS_RST  = 5'd4;

endpackage

@@ hdl/sacl_ram.sv @@
// Generic synchronous RAM with one write port and one registered read port.
`timescale 1ns / 1ps
module sacl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/sacl_victim.sv @@
// Comparator tree that picks the least recently used way of a set.
`timescale 1ns / 1ps
module sacl_victim #(
  parameter int NWAYS = 8,
  localparam int WAY_W = (NWAYS > 1) ? $clog2(NWAYS) : 1,
  localparam int PAD = 1 << $clog2(NWAYS)
) (
  input  logic [NWAYS*sacl_pkg::AGE_W-1:0] age_gap,
  input  logic [NWAYS-1:0]                 in_use,
  output logic [WAY_W-1:0]                 victim
);

  logic                      nd_ok  [1:2*PAD-1];
  logic [sacl_pkg::AGE_W-1:0] nd_d  [1:2*PAD-1];
  logic [WAY_W-1:0]          nd_i   [1:2*PAD-1];

  for (genvar g = 0; g < PAD; g++) begin : g_leaf
    if (g < NWAYS) begin : g_real
      assign nd_ok[PAD+g] = in_use[g];
      assign nd_d[PAD+g]  = age_gap[g*sacl_pkg::AGE_W +: sacl_pkg::AGE_W];
      assign nd_i[PAD+g]  = WAY_W'(g);
    end else begin : g_pad
      assign nd_ok[PAD+g] = 1'b0;
      assign nd_d[PAD+g]  = '0;
      assign nd_i[PAD+g]  = '0;
    end
  end

  for (genvar n = 1; n < PAD; n++) begin : g_node
    logic take_r;
    assign take_r = nd_ok[2*n+1] && (!nd_ok[2*n] || (nd_d[2*n+1] > nd_d[2*n]));
    assign nd_ok[n] = nd_ok[2*n] || nd_ok[2*n+1];
    assign nd_d[n]  = take_r ? nd_d[2*n+1] : nd_d[2*n];
    assign nd_i[n]  = take_r ? nd_i[2*n+1] : nd_i[2*n];
  end

  assign victim = nd_i[1];

endmodule

@@ hdl/set_assoc_cache_lru_sim_core.sv @@
// Top level of the set-associative cache simulator with exact LRU replacement.
//
// Configuration is written through the APB-style port: set_bits at byte address 0,
// ways_in_use at 4 and block_bits at 8. Writes are meant for idle periods only.
// An access is taken when start is high and busy is low; req_type and address are
// sampled at that edge. A load or a store gives one word, a modify gives two, and an
// unused access kind gives none and leaves busy low.
// Each word is shown on outcome, last and the three running totals for one cycle,
// marked by done, which is registered in the update state after the compare state;
// the second word of a modify follows after a further compare and update state.
// The receiver cannot stall the block. A lookup is a read of the whole set row from
// the tag memory, a compare stage, and an LRU selection stage that writes the row
// back. busy stays high up to the last word, so no new access is taken. The second
// lookup of a modify uses the row forwarded from the first instead of a new read.
// Reset clears the per-row valid flags, the access clock and the totals at once, so
// every set reads as empty; the memory needs no clearing pass.
`timescale 1ns / 1ps
module set_assoc_cache_lru_sim_core #(
  parameter int MAX_SET_BITS = sacl_pkg::MAX_SET_BITS_DEF,
  parameter int MAX_WAYS     = sacl_pkg::MAX_WAYS_DEF,
  parameter int ADDR_BITS    = sacl_pkg::ADDR_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sacl_pkg::PADDR_W-1:0]  paddr,
  input  logic [sacl_pkg::PDATA_W-1:0]  pwdata,
  output logic [sacl_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    req_type,
  input  logic [ADDR_BITS-1:0]          address,
  output logic                          done,
  output logic [1:0]                    outcome,
  output logic                          last,
  output logic [sacl_pkg::CNT_W-1:0]    hit_count,
  output logic [sacl_pkg::CNT_W-1:0]    miss_count,
  output logic [sacl_pkg::CNT_W-1:0]    eviction_count
);

  localparam int AGE_W  = sacl_pkg::AGE_W;
  localparam int SET_W  = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int NSETS  = 1 << MAX_SET_BITS;
  localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int LINE_W = 1 + ADDR_BITS + AGE_W;
  localparam int ROW_W  = MAX_WAYS * LINE_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CMP  = 2'd1;
  localparam logic [1:0] ST_UPD  = 2'd2;

  logic [3:0] set_bits;
  logic [3:0] ways_in_use;
  logic [4:0] block_bits;

  logic [1:0]           state;
  logic [SET_W-1:0]     set_q;
  logic [ADDR_BITS-1:0] tag_q;
  logic                 second_q;
  logic                 fwd_q;
  logic                 rv_q;
  logic [NSETS-1:0]     row_valid;
  logic [ROW_W-1:0]     row_q;
  logic [ROW_W-1:0]     rdata;
  logic [MAX_WAYS-1:0]  hit_q;
  logic [MAX_WAYS-1:0]  inv_q;
  logic [MAX_WAYS-1:0]  use_q;
  logic [MAX_WAYS*AGE_W-1:0] dist_q;
  logic [AGE_W-1:0]     access_clock;

  logic                 cfg_wr;
  logic                 accept;
  logic [4:0]           s_eff;
  logic [ADDR_BITS-1:0] addr_shift;
  logic [SET_W-1:0]     set_c;
  logic [5:0]           tag_sh;
  logic [ADDR_BITS-1:0] tag_c;
  logic [ROW_W-1:0]     src_row;
  logic [MAX_WAYS-1:0]  hit_c;
  logic [MAX_WAYS-1:0]  inv_c;
  logic [MAX_WAYS-1:0]  use_c;
  logic [MAX_WAYS*AGE_W-1:0] dist_c;
  logic [WAY_W-1:0]     victim;
  logic [WAY_W-1:0]     hit_way;
  logic [WAY_W-1:0]     inv_way;
  logic [WAY_W-1:0]     way_sel;
  logic [ROW_W-1:0]     new_row;
  logic                 upd;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy && (req_type != sacl_pkg::REQ_UNUSED);
  assign upd    = (state == ST_UPD);

  always_ff @(posedge clk) begin
    if (rst) begin
      set_bits    <= sacl_pkg::SET_BITS_RST;
      ways_in_use <= sacl_pkg::WAYS_IN_USE_RST;
      block_bits  <= sacl_pkg::BLOCK_BITS_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        sacl_pkg::REG_SET_BITS:    set_bits    <= pwdata[3:0];
        sacl_pkg::REG_WAYS_IN_USE: ways_in_use <= pwdata[3:0];
        sacl_pkg::REG_BLOCK_BITS:  block_bits  <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      sacl_pkg::REG_SET_BITS:    prdata = {28'd0, set_bits};
      sacl_pkg::REG_WAYS_IN_USE: prdata = {28'd0, ways_in_use};
      sacl_pkg::REG_BLOCK_BITS:  prdata = {27'd0, block_bits};
      default:                   prdata = '0;
    endcase
  end

  always_comb begin
    s_eff      = ({1'b0, set_bits} > 5'(MAX_SET_BITS)) ? 5'(MAX_SET_BITS) : {1'b0, set_bits};
    addr_shift = address >> block_bits;
    set_c      = addr_shift[SET_W-1:0] & ~({SET_W{1'b1}} << s_eff);
    tag_sh     = {1'b0, block_bits} + {1'b0, s_eff};
    tag_c      = address >> tag_sh;
  end

  sacl_ram #(
    .WIDTH(ROW_W),
    .DEPTH(NSETS)
  ) u_ram (
    .clk  (clk),
    .we   (upd),
    .waddr(set_q),
    .wdata(new_row),
    .raddr(set_c),
    .rdata(rdata)
  );

  always_comb begin
    src_row = fwd_q ? row_q : (rv_q ? rdata : '0);
    for (int w = 0; w < MAX_WAYS; w++) begin
      use_c[w] = (w == 0) || ({1'b0, ways_in_use} > 5'(w));
      hit_c[w] = use_c[w] && src_row[w*LINE_W + LINE_W - 1]
                 && (src_row[w*LINE_W + AGE_W +: ADDR_BITS] == tag_q);
      inv_c[w] = use_c[w] && !src_row[w*LINE_W + LINE_W - 1];
      dist_c[w*AGE_W +: AGE_W] = access_clock - src_row[w*LINE_W +: AGE_W];
    end
  end

  sacl_victim #(
    .NWAYS(MAX_WAYS)
  ) u_victim (
    .age_gap(dist_q),
    .in_use (use_q),
    .victim (victim)
  );

  always_comb begin
    hit_way = '0;
    inv_way = '0;
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (hit_q[w]) begin
        hit_way = WAY_W'(w);
      end
      if (inv_q[w]) begin
        inv_way = WAY_W'(w);
      end
    end
    if (|hit_q) begin
      way_sel = hit_way;
    end else if (|inv_q) begin
      way_sel = inv_way;
    end else begin
      way_sel = victim;
    end
    new_row = row_q;
    new_row[way_sel*LINE_W +: AGE_W] = access_clock;
    if (!(|hit_q)) begin
      new_row[way_sel*LINE_W + AGE_W +: ADDR_BITS] = tag_q;
      new_row[way_sel*LINE_W + LINE_W - 1] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      set_q <= set_c;
      tag_q <= tag_c;
      rv_q  <= row_valid[set_c];
    end
    if (state == ST_CMP) begin
      row_q  <= src_row;
      hit_q  <= hit_c;
      inv_q  <= inv_c;
      use_q  <= use_c;
      dist_q <= dist_c;
    end else if (upd) begin
      row_q <= new_row;
    end
    if (upd) begin
      outcome <= (|hit_q) ? sacl_pkg::OUT_HIT :
                 ((|inv_q) ? sacl_pkg::OUT_MISS : sacl_pkg::OUT_EVICT);
      last    <= !second_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      second_q       <= 1'b0;
      fwd_q          <= 1'b0;
      row_valid      <= '0;
      access_clock   <= '0;
      hit_count      <= '0;
      miss_count     <= '0;
      eviction_count <= '0;
      done           <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            state    <= ST_CMP;
            second_q <= (req_type == sacl_pkg::REQ_MODIFY);
            fwd_q    <= 1'b0;
          end
        end
        ST_CMP: begin
          state <= ST_UPD;
        end
        ST_UPD: begin
          done               <= 1'b1;
          row_valid[set_q]   <= 1'b1;
          access_clock       <= access_clock + AGE_W'(1);
          if (|hit_q) begin
            hit_count <= hit_count + {31'd0, (hit_count != '1)};
          end else begin
            miss_count <= miss_count + {31'd0, (miss_count != '1)};
            if (!(|inv_q)) begin
              eviction_count <= eviction_count + {31'd0, (eviction_count != '1)};
            end
          end
          if (second_q) begin
            second_q <= 1'b0;
            fwd_q    <= 1'b1;
            state    <= ST_CMP;
          end else begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

@@ hdl/sacl_checker.sv @@
// Port-level checker for the cache simulator core, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sacl_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic [1:0] req_type,
  input logic       done,
  input logic [1:0] outcome,
  input logic       last
);

  logic taken;

  assign taken = start && !busy;

  `ASSERT_IMPLY(a_outcome_code, clk, rst, done, outcome <= sacl_pkg::OUT_EVICT)
  `ASSERT_IMPLY(a_second_word, clk, rst, done && !last, ##2 (done && last))
  `ASSERT_IMPLY(a_unused_idle, clk, rst, taken && (req_type == sacl_pkg::REQ_UNUSED), ##1 !busy)
  `ASSERT_IMPLY(a_take_busy, clk, rst, taken && (req_type != sacl_pkg::REQ_UNUSED), ##1 busy)
  `ASSERT_ALWAYS(a_done_busy, clk, rst, !done || busy || $past(busy))

endmodule

bind set_assoc_cache_lru_sim_core sacl_checker u_sacl_checker (
  .clk     (clk),
  .rst     (rst),
  .start   (start),
  .busy    (busy),
  .req_type(req_type),
  .done    (done),
  .outcome (outcome),
  .last    (last)
);

@@ tb/sv/set_assoc_cache_lru_sim_core_tb.sv @@
// Self-checking testbench for the set-associative cache simulator with exact LRU.
`timescale 1ns / 1ps
module set_assoc_cache_lru_sim_core_tb;

  localparam int LINES       = (1 << sacl_pkg::MAX_SET_BITS_DEF) * sacl_pkg::MAX_WAYS_DEF;
  localparam int STALL_LIMIT = 2000;
  localparam int PHASE_WORDS = 275;

  typedef struct packed {
    logic [1:0]  outcome;
    logic        last;
    logic [31:0] hits;
    logic [31:0] misses;
    logic [31:0] evictions;
  } lookup_word_t;

  logic                           clk = 1'b0;
  logic                           rst;
  logic                           psel;
  logic                           penable;
  logic                           pwrite;
  logic [sacl_pkg::PADDR_W-1:0]   paddr;
  logic [sacl_pkg::PDATA_W-1:0]   pwdata;
  logic [sacl_pkg::PDATA_W-1:0]   prdata;
  logic                           pready;
  logic                           start;
  logic                           busy;
  logic [1:0]                     req_type;
  logic [47:0]                    address;
  logic                           done;
  logic [1:0]                     outcome;
  logic                           last;
  logic [sacl_pkg::CNT_W-1:0]     hit_count;
  logic [sacl_pkg::CNT_W-1:0]     miss_count;
  logic [sacl_pkg::CNT_W-1:0]     eviction_count;

  // Shadow copy of the cache contents and counters.
  logic [47:0]  tag_shadow [LINES];
  bit           valid_shadow [LINES];
  logic [31:0]  stamp_shadow [LINES];
  logic [31:0]  lookup_clock = '0;
  logic [31:0]  hit_total = '0;
  logic [31:0]  miss_total = '0;
  logic [31:0]  evict_total = '0;
  logic [3:0]   cfg_set_bits = sacl_pkg::SET_BITS_RST;
  logic [3:0]   cfg_ways = sacl_pkg::WAYS_IN_USE_RST;
  logic [4:0]   cfg_block_bits = sacl_pkg::BLOCK_BITS_RST;

  lookup_word_t pending_words [$];
  logic [47:0]  hot_addrs [16];

  int gap_pct = 0;
  int errors = 0;
  int idle_cycles = 0;
  int accesses_sent = 0;
  int ignored_sent = 0;
  int settings_used = 0;
  int words_checked = 0;
  int seen_hits = 0;
  int seen_misses = 0;
  int seen_evicts = 0;

  set_assoc_cache_lru_sim_core uut (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .start          (start),
    .busy           (busy),
    .req_type       (req_type),
    .address        (address),
    .done           (done),
    .outcome        (outcome),
    .last           (last),
    .hit_count      (hit_count),
    .miss_count     (miss_count),
    .eviction_count (eviction_count)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    for (int i = 0; i < LINES; i++) begin
      tag_shadow[i] = '0;
      valid_shadow[i] = 1'b0;
      stamp_shadow[i] = '0;
    end
  end

  function automatic logic [31:0] sat_inc(logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  function automatic int eff_set_bits();
    return (cfg_set_bits > sacl_pkg::MAX_SET_BITS_DEF) ? sacl_pkg::MAX_SET_BITS_DEF
                                                        : int'(cfg_set_bits);
  endfunction

  function automatic int eff_ways();
    if (cfg_ways == 0) return 1;
    return (cfg_ways > sacl_pkg::MAX_WAYS_DEF) ? sacl_pkg::MAX_WAYS_DEF : int'(cfg_ways);
  endfunction

  function automatic logic [1:0] cache_lookup(int base, int ways, logic [47:0] tag);
    logic [31:0] stamp;
    logic [31:0] best;
    logic [31:0] distance;
    int victim;
    stamp = lookup_clock;
    lookup_clock = lookup_clock + 32'd1;
    for (int w = 0; w < ways; w++) begin
      if (valid_shadow[base + w] && tag_shadow[base + w] == tag) begin
        stamp_shadow[base + w] = stamp;
        hit_total = sat_inc(hit_total);
        return sacl_pkg::OUT_HIT;
      end
    end
    for (int w = 0; w < ways; w++) begin
      if (!valid_shadow[base + w]) begin
        valid_shadow[base + w] = 1'b1;
        tag_shadow[base + w] = tag;
        stamp_shadow[base + w] = stamp;
        miss_total = sat_inc(miss_total);
        return sacl_pkg::OUT_MISS;
      end
    end
    victim = 0;
    best = stamp - stamp_shadow[base];
    for (int w = 1; w < ways; w++) begin
      distance = stamp - stamp_shadow[base + w];
      if (distance > best) begin
        best = distance;
        victim = w;
      end
    end
    tag_shadow[base + victim] = tag;
    stamp_shadow[base + victim] = stamp;
    miss_total = sat_inc(miss_total);
    evict_total = sat_inc(evict_total);
    return sacl_pkg::OUT_EVICT;
  endfunction

  function automatic void predict_access(logic [1:0] kind, logic [47:0] addr);
    int s;
    int b;
    int base;
    logic [47:0] tag;
    lookup_word_t w;
    if (kind == sacl_pkg::REQ_UNUSED) return;
    s = eff_set_bits();
    b = int'(cfg_block_bits);
    base = int'((addr >> b) & ((48'd1 << s) - 48'd1)) * sacl_pkg::MAX_WAYS_DEF;
    tag = addr >> (b + s);
    if (kind == sacl_pkg::REQ_MODIFY) begin
      w.outcome = cache_lookup(base, eff_ways(), tag);
      w.last = 1'b0;
      w.hits = hit_total;
      w.misses = miss_total;
      w.evictions = evict_total;
      pending_words.push_back(w);
    end
    w.outcome = cache_lookup(base, eff_ways(), tag);
    w.last = 1'b1;
    w.hits = hit_total;
    w.misses = miss_total;
    w.evictions = evict_total;
    pending_words.push_back(w);
  endfunction

  function automatic logic [47:0] make_addr(logic [47:0] tag, int set_idx, logic [47:0] off);
    int s;
    int b;
    s = eff_set_bits();
    b = int'(cfg_block_bits);
    return (tag << (b + s)) | (48'(set_idx) << b) | (off & ((48'd1 << b) - 48'd1));
  endfunction

  function automatic logic [47:0] rand_addr48();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    return r[47:0];
  endfunction

  // Entered and left at a falling edge; start stays high on return.
  task automatic send_access(input logic [1:0] kind, input logic [47:0] addr);
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    req_type <= kind;
    address <= addr;
    do @(posedge clk); while (busy);
    predict_access(kind, addr);
    if (kind == sacl_pkg::REQ_UNUSED) ignored_sent++;
    else accesses_sent++;
    @(negedge clk);
  endtask

  task automatic settle();
    start <= 1'b0;
    while (pending_words.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic check_reg(input logic [1:0] idx, input logic [31:0] want, input string name);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== want) begin
      $error("register %s: expected %0d, got %0d", name, want, prdata);
      errors++;
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_config(input logic [3:0] sb, input logic [3:0] wy, input logic [4:0] bb);
    write_reg(sacl_pkg::REG_SET_BITS, 32'(sb));
    cfg_set_bits = sb;
    write_reg(sacl_pkg::REG_WAYS_IN_USE, 32'(wy));
    cfg_ways = wy;
    write_reg(sacl_pkg::REG_BLOCK_BITS, 32'(bb));
    cfg_block_bits = bb;
    check_reg(sacl_pkg::REG_SET_BITS, 32'(sb), "set_bits");
    check_reg(sacl_pkg::REG_WAYS_IN_USE, 32'(wy), "ways_in_use");
    check_reg(sacl_pkg::REG_BLOCK_BITS, 32'(bb), "block_bits");
    settings_used++;
  endtask

  always @(posedge clk) begin : check_words
    lookup_word_t want;
    if (!rst && done) begin
      if (pending_words.size() == 0) begin
        $error("word arrived with nothing expected: outcome %0d", outcome);
        errors++;
      end else begin
        want = pending_words.pop_front();
        words_checked++;
        case (outcome)
          sacl_pkg::OUT_HIT:  seen_hits++;
          sacl_pkg::OUT_MISS: seen_misses++;
          default:            seen_evicts++;
        endcase
        if (outcome !== want.outcome) begin
          $error("outcome: expected %0d, got %0d", want.outcome, outcome);
          errors++;
        end
        if (last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, last);
          errors++;
        end
        if (hit_count !== want.hits) begin
          $error("hit_count: expected %0d, got %0d", want.hits, hit_count);
          errors++;
        end
        if (miss_count !== want.misses) begin
          $error("miss_count: expected %0d, got %0d", want.misses, miss_count);
          errors++;
        end
        if (eviction_count !== want.evictions) begin
          $error("eviction_count: expected %0d, got %0d", want.evictions, eviction_count);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (psel && penable)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  task automatic test_reset_defaults();
    check_reg(sacl_pkg::REG_SET_BITS, 32'(sacl_pkg::SET_BITS_RST), "set_bits");
    check_reg(sacl_pkg::REG_WAYS_IN_USE, 32'(sacl_pkg::WAYS_IN_USE_RST), "ways_in_use");
    check_reg(sacl_pkg::REG_BLOCK_BITS, 32'(sacl_pkg::BLOCK_BITS_RST), "block_bits");
    send_access(sacl_pkg::REQ_LOAD, 48'h0);
    send_access(sacl_pkg::REQ_LOAD, 48'h0);
    send_access(sacl_pkg::REQ_STORE, 48'hFFFF_FFFF_FFFF);
    send_access(sacl_pkg::REQ_MODIFY, 48'h10);
    send_access(sacl_pkg::REQ_UNUSED, 48'h0);
    send_access(sacl_pkg::REQ_LOAD, 48'h100);
    settle();
  endtask

  task automatic test_config_extremes();
    set_config(4'd15, 4'd0, 5'd31);
    send_access(sacl_pkg::REQ_STORE, 48'hFFFF_FFFF_FFFF);
    send_access(sacl_pkg::REQ_LOAD, 48'h0000_8000_0000);
    send_access(sacl_pkg::REQ_MODIFY, 48'hFFFF_FFFF_FFFF);
    send_access(sacl_pkg::REQ_UNUSED, 48'hAAAA_5555_AAAA);
    settle();
    set_config(4'd9, 4'd9, 5'd16);
    send_access(sacl_pkg::REQ_LOAD, 48'h1234_5678_9ABC);
    send_access(sacl_pkg::REQ_LOAD, 48'h1234_5678_9ABC);
    settle();
  endtask

  task automatic test_lru_order();
    set_config(4'd0, 4'd15, 5'd0);
    for (int i = 0; i < 8; i++) send_access(sacl_pkg::REQ_LOAD, 48'(100 + i));
    send_access(sacl_pkg::REQ_STORE, 48'd100);
    send_access(sacl_pkg::REQ_LOAD, 48'd200);
    send_access(sacl_pkg::REQ_MODIFY, 48'd300);
    settle();
  endtask

  task automatic test_reconfig_keeps_lines();
    set_config(sacl_pkg::SET_BITS_RST, sacl_pkg::WAYS_IN_USE_RST, sacl_pkg::BLOCK_BITS_RST);
    send_access(sacl_pkg::REQ_LOAD, 48'h0);
    send_access(sacl_pkg::REQ_STORE, 48'h100);
    settle();
  endtask

  task automatic test_random_traffic();
    logic [3:0] sb [6];
    logic [3:0] wy [6];
    logic [4:0] bb [6];
    int count;
    int r;
    int set_lim;
    logic [1:0] kind;
    logic [47:0] addr;
    sb = '{4'd2, 4'd0, 4'd8, 4'd1, 4'd3, 4'd0};
    wy = '{4'd4, 4'd8, 4'd8, 4'd2, 4'd1, 4'd0};
    bb = '{5'd4, 5'd0, 5'd16, 5'd31, 5'd6, 5'd0};
    sb[5] = 4'($urandom_range(15));
    wy[5] = 4'($urandom_range(15));
    bb[5] = 5'($urandom_range(31));
    for (int phase = 0; phase < 6; phase++) begin
      gap_pct = (phase < 2) ? 7 : (phase < 4) ? 55 : 0;
      set_config(sb[phase], wy[phase], bb[phase]);
      set_lim = (eff_set_bits() == 0) ? 0 : ((1 << eff_set_bits()) - 1);
      if (set_lim > 3) set_lim = 3;
      foreach (hot_addrs[i]) begin
        hot_addrs[i] = make_addr(48'($urandom_range(eff_ways() + 2)),
                                 $urandom_range(set_lim), rand_addr48());
      end
      count = 0;
      while (count < PHASE_WORDS) begin
        kind = ($urandom_range(99) < 5) ? sacl_pkg::REQ_UNUSED : 2'($urandom_range(2));
        r = $urandom_range(99);
        if (r < 70) begin
          addr = hot_addrs[$urandom_range(15)] |
                 (rand_addr48() & ((48'd1 << cfg_block_bits) - 48'd1));
        end else if (r < 90) begin
          addr = make_addr(48'($urandom_range(7)), $urandom_range(255), rand_addr48());
        end else begin
          addr = rand_addr48();
        end
        send_access(kind, addr);
        if (kind != sacl_pkg::REQ_UNUSED) count++;
      end
      settle();
    end
  endtask

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    start = 1'b0;
    req_type = sacl_pkg::REQ_LOAD;
    address = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_config_extremes();
    test_lru_order();
    test_reconfig_keeps_lines();
    test_random_traffic();
    $display("Ran %0d accesses and %0d ignored ones over %0d register settings.",
             accesses_sent, ignored_sent, settings_used);
    $display("Checked %0d words: %0d hits, %0d misses, %0d evictions; %0d errors.",
             words_checked, seen_hits, seen_misses, seen_evicts, errors);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
